@@ sv/prime_count_odd_bit_sieve_unit_defines.svh @@
// assertion macros for the prime count sieve unit
// no dependencies; included by the rtl files that carry assertions
`ifndef PRIME_COUNT_ODD_BIT_SIEVE_UNIT_DEFINES_SVH
`define PRIME_COUNT_ODD_BIT_SIEVE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PCS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pcs assertion failed");
`define PCS_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pcs assertion failed");
`else
`define PCS_ASSERT(lbl, clk, rstn, prop)
`define PCS_ASSERT_NR(lbl, clk, prop)
`endif
`endif

@@ sv/pcs_pkg.sv @@
// constants, types and index helpers for the prime count sieve unit
// no dependencies; imported by pcs_step_unit, the top level, the checker and the testbench
`default_nettype none
package pcs_pkg;

    localparam int MAX_LIMIT   = 65535;
    localparam int WORD_BITS   = 32;
    localparam int STORE_WORDS = (MAX_LIMIT / 2) / WORD_BITS + 1;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int LIMIT_W     = 16;
    localparam int COUNT_W     = 13;
    localparam int CAND_W      = 17;
    localparam int MULT_W      = 18;
    localparam int PROD_W      = 2 * LIMIT_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CAND_RD,
        ST_CAND_CHK,
        ST_SQ_CHK,
        ST_NEXT,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [MULT_W-1:0]  a;
        logic [MULT_W-1:0]  b;
        logic [LIMIT_W-1:0] lim;
    } step_op_t;

    typedef struct packed {
        logic [MULT_W-1:0] sum;
        logic              gt;
    } step_res_t;

    // odd k sits at bit (k-1)/2 of the store
    function automatic logic [ADDR_W-1:0] word_of(input logic [MULT_W-1:0] k);
        word_of = k[ADDR_W+BIT_W:BIT_W+1];
    endfunction

    function automatic logic [BIT_W-1:0] bit_of(input logic [MULT_W-1:0] k);
        bit_of = k[BIT_W:1];
    endfunction

endpackage
`default_nettype wire

@@ sv/pcs_step_unit.sv @@
// shared add and limit compare used by the clear, candidate, square check and marking steps of the sieve sequencer
// depends on pcs_pkg
`default_nettype none
module pcs_step_unit (
    input  pcs_pkg::step_op_t  op_i,
    output pcs_pkg::step_res_t res_o
);
    import pcs_pkg::*;

    always_comb begin
        res_o.sum = op_i.a + op_i.b;
        res_o.gt  = op_i.a > MULT_W'(op_i.lim);
    end

endmodule
`default_nettype wire

@@ sv/prime_count_odd_bit_sieve_unit.sv @@
// top level of the prime count sieve: sequencer, odd-only bit store, result register
// depends on pcs_pkg, pcs_step_unit and prime_count_odd_bit_sieve_unit_defines.svh
//
//  channel | ports                       | beat
//  input   | s_valid s_ready s_limit     | one limit n per request
//  result  | m_valid m_ready m_prime_count | one count per request
//
// a request's run time grows with each odd candidate, each prime whose square is within n
// and each marked multiple, on top of the clearing pass, and is set by the single port
// bit store (read, then write, of one word per step)
// each request starts with a clearing pass over all 1024 words of the store
// s_ready is high only between requests; a waiting result does not block a new one
// aresetn clears the sequencer and the result valid, not the store
`default_nettype none
`include "prime_count_odd_bit_sieve_unit_defines.svh"
module prime_count_odd_bit_sieve_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [pcs_pkg::LIMIT_W-1:0]   s_limit,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [pcs_pkg::COUNT_W-1:0]        m_prime_count
);
    import pcs_pkg::*;

    state_t               state_reg, state_next;
    logic [LIMIT_W-1:0]   n_reg, n_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    logic [CAND_W-1:0]    cand_reg, cand_next;
    logic [MULT_W-1:0]    mult_reg, mult_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;

    logic [WORD_BITS-1:0] mem [STORE_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 mem_we, mem_re;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    logic [WORD_BITS-1:0] wr_data;

    step_op_t             op;
    step_res_t            res;
    logic [COUNT_W-1:0]   count_inc;
    logic [MULT_W-1:0]    cand_ext;

    pcs_step_unit u_step (
        .op_i  (op),
        .res_o (res)
    );

    assign cand_ext  = MULT_W'(cand_reg);
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = out_valid_reg;
    assign m_prime_count = out_count_reg;

    // operand select for the shared step unit
    always_comb begin
        op.a   = cand_ext;
        op.b   = MULT_W'(2);
        op.lim = n_reg;
        case (state_reg)
            ST_CLEAR: begin
                op.a = MULT_W'(clr_reg);
                op.b = MULT_W'(1);
            end
            ST_SQ_CHK: begin
                op.a = MULT_W'(prod_reg[LIMIT_W-1:0]);
            end
            ST_MARK_RD: begin
                op.a = mult_reg;
            end
            ST_MARK_WR: begin
                op.a = mult_reg;
                op.b = {cand_reg, 1'b0};
            end
            default: begin
                op.a = cand_ext;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        clr_next       = clr_reg;
        cand_next      = cand_reg;
        mult_next      = mult_reg;
        prod_next      = prod_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        wr_addr        = clr_reg;
        wr_data        = '0;
        rd_addr        = word_of(cand_ext);

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    n_next     = s_limit;
                    clr_next   = '0;
                    count_next = '0;
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                mem_we   = 1'b1;
                clr_next = res.sum[ADDR_W-1:0];
                if (clr_reg == ADDR_W'(STORE_WORDS - 1)) begin
                    if (n_reg[LIMIT_W-1:1] == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        count_next = count_inc;
                        cand_next  = CAND_W'(3);
                        state_next = ST_CAND_RD;
                    end
                end
            end
            ST_CAND_RD: begin
                if (res.gt) begin
                    state_next = ST_FINISH;
                end else begin
                    mem_re     = 1'b1;
                    state_next = ST_CAND_CHK;
                end
            end
            ST_CAND_CHK: begin
                if (rd_data_reg[bit_of(cand_ext)]) begin
                    cand_next  = res.sum[CAND_W-1:0];
                    state_next = ST_CAND_RD;
                end else begin
                    count_next = count_inc;
                    prod_next  = PROD_W'(cand_reg[LIMIT_W-1:0]) *
                                 PROD_W'(cand_reg[LIMIT_W-1:0]);
                    state_next = ST_SQ_CHK;
                end
            end
            ST_SQ_CHK: begin
                if ((|prod_reg[PROD_W-1:LIMIT_W]) || res.gt) begin
                    state_next = ST_NEXT;
                end else begin
                    mult_next  = MULT_W'(prod_reg[LIMIT_W-1:0]);
                    state_next = ST_MARK_RD;
                end
            end
            ST_NEXT: begin
                cand_next  = res.sum[CAND_W-1:0];
                state_next = ST_CAND_RD;
            end
            ST_MARK_RD: begin
                rd_addr = word_of(mult_reg);
                if (res.gt) begin
                    state_next = ST_NEXT;
                end else begin
                    mem_re     = 1'b1;
                    state_next = ST_MARK_WR;
                end
            end
            ST_MARK_WR: begin
                mem_we     = 1'b1;
                wr_addr    = word_of(mult_reg);
                wr_data    = rd_data_reg | (WORD_BITS'(1) << bit_of(mult_reg));
                mult_next  = res.sum;
                state_next = ST_MARK_RD;
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg         <= n_next;
        clr_reg       <= clr_next;
        cand_reg      <= cand_next;
        mult_reg      <= mult_next;
        prod_reg      <= prod_next;
        count_reg     <= count_next;
        out_count_reg <= out_count_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    `PCS_ASSERT(a_accept_clears, aclk, aresetn,
        (s_valid && s_ready) |=> (state_reg == ST_CLEAR))
    `PCS_ASSERT(a_write_after_read, aclk, aresetn,
        (state_reg == ST_MARK_WR) |-> ($past(state_reg) == ST_MARK_RD))
    `PCS_ASSERT(a_mult_odd, aclk, aresetn, (state_reg == ST_MARK_RD) |-> mult_reg[0])
    `PCS_ASSERT(a_cand_odd, aclk, aresetn, (state_reg == ST_CAND_RD) |-> cand_reg[0])
    `PCS_ASSERT(a_finish_loads, aclk, aresetn,
        (state_reg == ST_FINISH && (!out_valid_reg || m_ready)) |=>
        (out_valid_reg && state_reg == ST_IDLE))

endmodule
`default_nettype wire

@@ dv/pcs_count_checker.sv @@
// result checker for the prime count sieve unit: predicts each count and compares beats
// depends on pcs_pkg; instantiated by tb_prime_count_odd_bit_sieve_unit
`default_nettype none
module pcs_count_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire logic [pcs_pkg::LIMIT_W-1:0]   s_limit,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire logic [pcs_pkg::COUNT_W-1:0]   m_prime_count,
    output int                                 fail_count,
    output int                                 pending
);
    import pcs_pkg::*;

    typedef struct packed {
        logic [LIMIT_W-1:0] limit;
        logic [COUNT_W-1:0] count;
    } count_exp_t;

    count_exp_t expected_counts [$];
    count_exp_t head;

    // odd-only sieve, one composite bit per odd number
    function automatic logic [COUNT_W-1:0] count_primes_upto(input logic [LIMIT_W-1:0] limit);
        logic [WORD_BITS-1:0] odd_composite [STORE_WORDS];
        logic [COUNT_W-1:0]   tally;
        int unsigned          n;
        int unsigned          cand;
        int unsigned          mult;
        int unsigned          idx;
        n = limit;
        if (n > MAX_LIMIT)
            n = MAX_LIMIT;
        for (int w = 0; w < STORE_WORDS; w++)
            odd_composite[w] = '0;
        tally = '0;
        if (n >= 2) begin
            tally = COUNT_W'(1);
            for (cand = 3; cand <= n; cand += 2) begin
                idx = (cand - 1) / 2;
                if (!odd_composite[idx / WORD_BITS][idx % WORD_BITS]) begin
                    if (tally != COUNT_MAX)
                        tally = tally + COUNT_W'(1);
                    for (mult = cand * cand; mult <= n; mult += 2 * cand) begin
                        idx = (mult - 1) / 2;
                        odd_composite[idx / WORD_BITS][idx % WORD_BITS] = 1'b1;
                    end
                end
            end
        end
        return tally;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                head.limit = s_limit;
                head.count = count_primes_upto(s_limit);
                expected_counts = {expected_counts, head};
            end
            if (m_valid && m_ready) begin
                if (expected_counts.size() == 0) begin
                    $display("%0t: unexpected result beat, prime_count %0d",
                             $time, m_prime_count);
                    fail_count <= fail_count + 1;
                end else begin
                    head = expected_counts.pop_front();
                    if (m_prime_count !== head.count) begin
                        $display("%0t: prime_count for limit %0d: expected %0d, got %0d",
                                 $time, head.limit, head.count, m_prime_count);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_counts.size();
        end
    end
endmodule
`default_nettype wire

@@ dv/tb_prime_count_odd_bit_sieve_unit.sv @@
// testbench top for prime_count_odd_bit_sieve_unit: clock, reset, stimulus and verdict
// depends on pcs_pkg, the block and pcs_count_checker
`default_nettype none
module tb_prime_count_odd_bit_sieve_unit;
    import pcs_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int RANDOM_ITEMS   = 78;
    localparam int DRAIN_EVERY    = 25;
    localparam int SETTLE_CYCLES  = 64;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [LIMIT_W-1:0] s_limit       = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [COUNT_W-1:0] m_prime_count;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles   = 0;

    // small ends, prime squares and their neighbours, word and store edges
    logic [LIMIT_W-1:0] directed_limits [22] = '{
        16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd8, 16'd9, 16'd10, 16'd24, 16'd25,
        16'd26, 16'd48, 16'd49, 16'd120, 16'd121, 16'd255, 16'd256, 16'd1023, 16'd1024,
        16'd16384, 16'd65535
    };

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    prime_count_odd_bit_sieve_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_limit       (s_limit),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_prime_count (m_prime_count)
    );

    pcs_count_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_limit       (s_limit),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_prime_count (m_prime_count),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 150);
    endfunction

    // mostly small limits, the odd one across the whole range
    function automatic logic [LIMIT_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return LIMIT_W'($urandom_range(0, 3));
        if (r < 65)
            return LIMIT_W'($urandom_range(0, 300));
        if (r < 97)
            return LIMIT_W'($urandom_range(0, 4095));
        return LIMIT_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_limit(input logic [LIMIT_W-1:0] limit);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_limit <= limit;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        do @(posedge aclk); while (pending != 0);
    endtask

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_prime_count_odd_bit_sieve_unit failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int hold;
        int stall;
        @(posedge aclk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 400) : $urandom_range(1, 8);
            repeat (hold) @(posedge aclk);
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_limits[i])
            send_limit(directed_limits[i]);
        s_valid <= 1'b0;
        drain_results();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            send_limit(pick_limit());
            if (i % DRAIN_EVERY == DRAIN_EVERY - 1) begin
                s_valid <= 1'b0;
                drain_results();
            end
        end
        s_valid <= 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("tb_prime_count_odd_bit_sieve_unit passed");
        else
            $display("tb_prime_count_odd_bit_sieve_unit failed");
        $finish;
    end
endmodule
`default_nettype wire
